// File: src/rcm_pkg.sv
// Package: shared types and constants of the reverse Cuthill-McKee orderer.
`timescale 1ns / 1ps
`default_nettype none
package rcm_pkg;
  localparam int unsigned MaxOrder = 16;
  localparam int unsigned EntryW  = 64;
  localparam int unsigned ThreshW = 63;
  localparam int unsigned OrderW  = 5;
  localparam int unsigned CfgW    = 63;
  localparam int unsigned IdxW    = 4;
  localparam logic [ThreshW-1:0] ThreshReset = 63'h3E112E0BE826D695;

  typedef enum logic [0:0] {
    CFG_ORDER  = 1'b0,
    CFG_THRESH = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DEG,
    ST_SEARCH,
    ST_POP,
    ST_SCAN,
    ST_EMIT
  } state_e;

  // one input request
  typedef struct packed {
    logic [EntryW-1:0] entry_bits;
  } entry_t;

  // one result request
  typedef struct packed {
    logic [IdxW-1:0] node_index;
    logic [IdxW-1:0] position;
    logic            last_of_run;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_walk;
    logic deg_step;
    logic search_step;
    logic start_walk;
    logic pop;
    logic scan_step;
    logic emit_step;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_entry;
    logic deg_done;
    logic search_done;
    logic queue_empty;
    logic all_placed;
    logic scan_done;
    logic emit_last;
  } stat_t;
endpackage
`default_nettype wire

// File: src/rcm_stream_if.sv
// Interface: valid/ready channel carrying a generic payload.
`timescale 1ns / 1ps
`default_nettype none
interface rcm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/rcm_ctrl.sv
// Controller: state machine sequencing load, degree count, walk and emit.
`timescale 1ns / 1ps
`default_nettype none
module rcm_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire rcm_pkg::stat_t stat_i,
  output rcm_pkg::cmd_t      cmd_o
);
  rcm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rcm_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      rcm_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i && stat_i.last_entry) begin
          cmd_o.clear_walk = 1'b1;
          state_d = rcm_pkg::ST_DEG;
        end
      end
      rcm_pkg::ST_DEG: begin
        cmd_o.deg_step = 1'b1;
        if (stat_i.deg_done) state_d = rcm_pkg::ST_SEARCH;
      end
      rcm_pkg::ST_SEARCH: begin
        if (stat_i.all_placed) begin
          state_d = rcm_pkg::ST_EMIT;
        end else begin
          cmd_o.search_step = 1'b1;
          if (stat_i.search_done) begin
            cmd_o.start_walk = 1'b1;
            state_d = rcm_pkg::ST_POP;
          end
        end
      end
      rcm_pkg::ST_POP: begin
        if (stat_i.all_placed) begin
          state_d = rcm_pkg::ST_EMIT;
        end else if (stat_i.queue_empty) begin
          state_d = rcm_pkg::ST_SEARCH;
        end else begin
          cmd_o.pop = 1'b1;
          state_d = rcm_pkg::ST_SCAN;
        end
      end
      rcm_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_done) state_d = rcm_pkg::ST_POP;
      end
      rcm_pkg::ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.emit_step = 1'b1;
          if (stat_i.emit_last) state_d = rcm_pkg::ST_LOAD;
        end
      end
      default: state_d = rcm_pkg::ST_LOAD;
    endcase
  end

  // A result is offered only in the emit phase, and input only in load.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(in_ready_o && out_valid_o))
    else $error("input and output phases overlap");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && stat_i.emit_last) |=> in_ready_o)
    else $error("no return to load after last result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rcm_pkg::ST_SCAN && !stat_i.scan_done) |=> state_q == rcm_pkg::ST_SCAN)
    else $error("scan left early");
endmodule
`default_nettype wire

// File: src/rcm_datapath.sv
// Datapath: adjacency store, degrees, flags, walk queue and visit order.
`timescale 1ns / 1ps
`default_nettype none
module rcm_datapath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_idx_i,
  input  wire logic [rcm_pkg::CfgW-1:0]     cfg_data_i,
  input  wire logic                         in_fire_i,
  input  wire logic [rcm_pkg::EntryW-1:0]   entry_i,
  input  wire rcm_pkg::cmd_t                cmd_i,
  output rcm_pkg::stat_t                    stat_o,
  output logic [rcm_pkg::IdxW-1:0]          node_o,
  output logic [rcm_pkg::IdxW-1:0]          pos_o,
  output logic                              last_o
);
  localparam int unsigned MaxOrder = rcm_pkg::MaxOrder;
  localparam int unsigned NW = $clog2(MaxOrder);
  localparam int unsigned CW = $clog2(MaxOrder + 1);

  logic [CW-1:0]              order_q;
  logic [rcm_pkg::ThreshW-1:0] thresh_q;
  logic [NW-1:0]              row_q, col_q;
  logic [MaxOrder-1:0]        adj_q [MaxOrder];
  logic [CW-1:0]              deg_q [MaxOrder];
  logic [MaxOrder-1:0]        placed_q, visited_q;
  logic [NW-1:0]              queue_q [MaxOrder];
  logic [NW-1:0]              visit_q [MaxOrder];
  logic [CW-1:0]              head_q, tail_q, nplaced_q, emit_q;
  logic [NW-1:0]              idx_q;     // shared sweep index
  logic [NW-1:0]              best_q;
  logic [CW-1:0]              bestdeg_q;
  logic                       found_q;
  logic [NW-1:0]              cur_q;
  logic [MaxOrder-1:0]        row_r_q;   // row of the node being scanned

  logic [CW-1:0]        wr_order, last_idx, nm1;
  logic [MaxOrder-1:0]  colmask, cnt_row;
  logic [CW-1:0]        pop;
  logic                 edge_bit, sweep_end, cand_better;
  logic [CW-1:0]        emit_rev;

  always_comb begin
    logic [5:0] v;
    v = {1'b0, cfg_data_i[rcm_pkg::OrderW-1:0]};
    if (v == '0) wr_order = CW'(1);
    else if (v > 6'(MaxOrder)) wr_order = CW'(MaxOrder);
    else wr_order = CW'(v);
  end

  assign nm1 = order_q - CW'(1);
  assign last_idx = nm1;
  assign sweep_end = (CW'(idx_q) == last_idx);
  always_comb begin
    for (int i = 0; i < MaxOrder; i++) colmask[i] = (i < int'(order_q));
  end
  assign cnt_row = adj_q[idx_q] & colmask;
  always_comb begin
    pop = '0;
    for (int i = 0; i < MaxOrder; i++) pop = pop + CW'(cnt_row[i]);
  end
  assign edge_bit = entry_i[rcm_pkg::EntryW-2:0] > thresh_q;
  assign cand_better = !placed_q[idx_q] && (!found_q || deg_q[idx_q] < bestdeg_q);

  assign stat_o.last_entry  = (CW'(row_q) == last_idx) && (CW'(col_q) == last_idx);
  assign stat_o.deg_done    = sweep_end;
  assign stat_o.search_done = sweep_end;
  assign stat_o.queue_empty = (head_q == tail_q);
  assign stat_o.all_placed  = (nplaced_q == order_q);
  assign stat_o.scan_done   = sweep_end;
  assign stat_o.emit_last   = (emit_q == nm1);

  assign emit_rev = nm1 - emit_q;
  assign node_o = visit_q[emit_rev[NW-1:0]];
  assign pos_o  = emit_q[NW-1:0];
  assign last_o = stat_o.emit_last;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q   <= CW'(MaxOrder);
      thresh_q  <= rcm_pkg::ThreshReset;
      row_q     <= '0;
      col_q     <= '0;
      placed_q  <= '0;
      visited_q <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      nplaced_q <= '0;
      emit_q    <= '0;
      idx_q     <= '0;
      found_q   <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == rcm_pkg::CFG_ORDER) begin
        order_q <= wr_order;
        row_q   <= '0;
        col_q   <= '0;
      end
      if (cfg_we_i && cfg_idx_i == rcm_pkg::CFG_THRESH) thresh_q <= cfg_data_i;
      if (in_fire_i) begin
        if (CW'(col_q) == last_idx) begin
          col_q <= '0;
          row_q <= (CW'(row_q) == last_idx) ? '0 : row_q + NW'(1);
        end else begin
          col_q <= col_q + NW'(1);
        end
      end
      if (cmd_i.clear_walk) begin
        placed_q <= '0; visited_q <= '0; head_q <= '0; tail_q <= '0;
        nplaced_q <= '0; emit_q <= '0; idx_q <= '0; found_q <= 1'b0;
      end
      if (cmd_i.deg_step || cmd_i.search_step || cmd_i.scan_step)
        idx_q <= sweep_end ? '0 : idx_q + NW'(1);
      if (cmd_i.search_step) begin
        found_q <= sweep_end ? 1'b0 : (found_q || !placed_q[idx_q]);
      end
      if (cmd_i.start_walk) begin
        visited_q[cand_better ? idx_q : best_q] <= 1'b1;
        tail_q <= tail_q + CW'(1);
      end
      if (cmd_i.pop) begin
        head_q <= head_q + CW'(1);
        nplaced_q <= nplaced_q + CW'(1);
        placed_q[queue_q[head_q[NW-1:0]]] <= 1'b1;
      end
      if (cmd_i.scan_step && row_r_q[idx_q] && !visited_q[idx_q] && tail_q < order_q) begin
        visited_q[idx_q] <= 1'b1;
        tail_q <= tail_q + CW'(1);
      end
      if (cmd_i.emit_step) emit_q <= stat_o.emit_last ? '0 : emit_q + CW'(1);
    end
  end

  // payload storage
  always_ff @(posedge clk_i) begin
    if (in_fire_i) adj_q[row_q][col_q] <= edge_bit;
    if (cmd_i.deg_step) deg_q[idx_q] <= pop;
    if (cmd_i.search_step && cand_better) begin
      best_q    <= idx_q;
      bestdeg_q <= deg_q[idx_q];
    end
    if (cmd_i.start_walk) queue_q[tail_q[NW-1:0]] <= cand_better ? idx_q : best_q;
    if (cmd_i.pop) begin
      cur_q   <= queue_q[head_q[NW-1:0]];
      row_r_q <= adj_q[queue_q[head_q[NW-1:0]]] & colmask;
      visit_q[nplaced_q[NW-1:0]] <= queue_q[head_q[NW-1:0]];
    end
    if (cmd_i.scan_step && row_r_q[idx_q] && !visited_q[idx_q] && tail_q < order_q)
      queue_q[tail_q[NW-1:0]] <= idx_q;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) head_q <= tail_q)
    else $error("queue head passed tail");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.pop |=> visited_q[cur_q])
    else $error("popped node never marked visited");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.pop |-> nplaced_q < order_q)
    else $error("placed count beyond order");
endmodule
`default_nettype wire

// File: src/reverse_cuthill_mckee_order.sv
// Top level: reverse Cuthill-McKee ordering of a streamed square matrix.
// Usage:
//  - in_if carries one IEEE double entry per request, row-major, for an
//    N x N matrix, N = order_in_use. An entry is an edge when its
//    magnitude bit pattern exceeds threshold_bits.
//  - Entries load one per cycle. The last entry starts the degree sweep
//    and the breadth-first walk: each walk begins with a search for its
//    start node, each visited node takes a pop and then a neighbor scan,
//    and each walk ends in the pop state when it finds its queue drained
//    or all nodes placed. A matrix takes from 1 to N walks.
//  - It then offers N results on out_if, reversed visit order, one per
//    cycle while the receiver takes them; last_of_run marks the final one.
//    Entries are taken again the cycle after the last result.
//  - A stalled receiver holds the current result; no entry is taken
//    until the last result has been delivered.
//  - Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) go in while
//    idle; writing order_in_use restarts the load at entry 0.
//  - Reset (rst_ni low, asynchronous) returns to loading with order 16
//    and the default 1e-9 threshold.
`timescale 1ns / 1ps
`default_nettype none
module reverse_cuthill_mckee_order (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic                     cfg_idx_i,
  input  wire logic [rcm_pkg::CfgW-1:0] cfg_data_i,
  rcm_stream_if.sink                    in_if,
  rcm_stream_if.source                  out_if
);
  rcm_pkg::cmd_t  cmd;
  rcm_pkg::stat_t stat;
  logic in_ready;
  logic [rcm_pkg::IdxW-1:0] node, pos;
  logic last;

  assign in_if.ready = in_ready;
  assign out_if.data.node_index  = node;
  assign out_if.data.position    = pos;
  assign out_if.data.last_of_run = last;

  rcm_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rcm_datapath u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_fire_i (in_if.valid && in_ready),
    .entry_i   (in_if.data.entry_bits),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .node_o    (node),
    .pos_o     (pos),
    .last_o    (last)
  );
endmodule
`default_nettype wire
